// ----- hw/rtl/tks_pkg.sv -----
// Shared constants for the top-K sorted insertion block.
// Used by tks_cell and top_k_sorted_insert; depends on nothing.
package tks_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int COUNT_BITS_DEF = 32;
  localparam int TOPIC_BITS_DEF = 16;

  localparam int KIND_W  = 2;
  localparam int INDEX_W = 4;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

  // broadcast control from the top level to every cell
  typedef struct packed {
    logic ins;  // accepted insert this cycle
    logic clr;  // empty the list
  } cell_ctl_t;

endpackage

// ----- hw/rtl/tks_cell.sv -----
// One list slot: holds a (count, topic) pair and a valid bit, compares against
// the broadcast pair and hands its contents to the right neighbor. Uses tks_pkg.
module tks_cell #(
  parameter int COUNT_BITS = tks_pkg::COUNT_BITS_DEF,
  parameter int TOPIC_BITS = tks_pkg::TOPIC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tks_pkg::cell_ctl_t    ctl,
  input  logic [COUNT_BITS-1:0] new_count,
  input  logic [TOPIC_BITS-1:0] new_topic,
  input  logic                  left_valid,  // tied high on the first cell
  input  logic                  left_stay,   // tied high on the first cell
  input  logic [COUNT_BITS-1:0] left_count,
  input  logic [TOPIC_BITS-1:0] left_topic,
  output logic                  valid,
  output logic                  stay,
  output logic [COUNT_BITS-1:0] count,
  output logic [TOPIC_BITS-1:0] topic
);

  logic                  valid_r, valid_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [TOPIC_BITS-1:0] topic_r, topic_nxt;
  logic                  key_lt;

  // held key strictly below the new key
  assign key_lt = (count_r < new_count) || ((count_r == new_count) && (topic_r < new_topic));
  // equal keys stay ahead of the new pair
  assign stay = valid_r && !key_lt;

  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    topic_nxt = topic_r;
    if (ctl.clr) begin
      valid_nxt = 1'b0;
    end else if (ctl.ins && !stay) begin
      valid_nxt = valid_r | left_valid;
      if (left_stay) begin
        count_nxt = new_count;
        topic_nxt = new_topic;
      end else begin
        count_nxt = left_count;
        topic_nxt = left_topic;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    count_r <= count_nxt;
    topic_r <= topic_nxt;
  end

  assign valid = valid_r;
  assign count = count_r;
  assign topic = topic_r;

endmodule

// ----- hw/rtl/top_k_sorted_insert.sv -----
// Top level of the top-K sorted insertion block: stream ports, cell row,
// held counter and result register. Depends on tks_pkg and tks_cell.
//
// Keeps the DEPTH largest (count, topic) pairs in descending key order,
// count major, topic minor; a new pair goes behind equal keys.
// Input words carry a kind in in_tuser (insert, clear, read) and the pair
// plus a read index in in_tdata. Every input word yields one output word:
// accepted flag, held count, the largest pair, and the pair read (zero on
// anything but a read within the held count).
// The result is registered and appears in the cycle after the input word is taken.
// One word is taken per cycle while the receiver does not stall. All cells compare
// against the incoming pair in parallel and each one either keeps its pair, takes
// the new pair or takes its left neighbor's, so the insert is done as the word is taken.
// When full, a pair enters only if its count beats the last held count,
// and the last pair falls off the end of the row.
// Reset (rst_n low, synchronous) empties the list and drops any pending
// result. When the receiver stalls, the result register holds its word and
// in_tready stays low until it is taken; a new word is taken in the same
// cycle the pending result leaves.
module top_k_sorted_insert #(
  parameter int DEPTH      = tks_pkg::DEPTH_DEF,
  parameter int COUNT_BITS = tks_pkg::COUNT_BITS_DEF,
  parameter int TOPIC_BITS = tks_pkg::TOPIC_BITS_DEF,
  localparam int HELD_W    = $clog2(DEPTH + 1),
  localparam int IN_FW     = COUNT_BITS + TOPIC_BITS + tks_pkg::INDEX_W,
  localparam int IN_DW     = ((IN_FW + 7) / 8) * 8,
  localparam int OUT_FW    = 1 + HELD_W + 2 * (COUNT_BITS + TOPIC_BITS),
  localparam int OUT_DW    = ((OUT_FW + 7) / 8) * 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // from bit 0: count, topic, index, zero pad
  input  logic [IN_DW-1:0]           in_tdata,
  // kind
  input  logic [tks_pkg::KIND_W-1:0] in_tuser,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // from bit 0: accepted, held, max_count, max_topic, read_count, read_topic, zero pad
  output logic [OUT_DW-1:0]          out_tdata
);

  localparam int IDX_LO = COUNT_BITS + TOPIC_BITS;

  logic [COUNT_BITS-1:0]       in_count;
  logic [TOPIC_BITS-1:0]       in_topic;
  logic [tks_pkg::INDEX_W-1:0] in_index;
  logic                        fire;
  logic                        full;
  logic                        ins_ok;
  tks_pkg::cell_ctl_t          ctl;

  logic [DEPTH-1:0]      valid_a;
  logic [DEPTH-1:0]      stay_a;
  logic [COUNT_BITS-1:0] count_a [DEPTH];
  logic [TOPIC_BITS-1:0] topic_a [DEPTH];

  logic [HELD_W-1:0]     held_r, held_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  acc_r;
  logic [COUNT_BITS-1:0] rd_count_r, rd_count_nxt;
  logic [TOPIC_BITS-1:0] rd_topic_r, rd_topic_nxt;

  assign in_count = in_tdata[COUNT_BITS-1:0];
  assign in_topic = in_tdata[COUNT_BITS +: TOPIC_BITS];
  assign in_index = in_tdata[IDX_LO +: tks_pkg::INDEX_W];

  // result register frees up as its word leaves
  assign in_tready = !out_valid_r || out_tready;
  assign fire      = in_tvalid && in_tready;

  assign full   = (held_r == HELD_W'(DEPTH));
  assign ins_ok = (in_tuser == tks_pkg::KIND_INSERT) &&
                  (!full || (in_count > count_a[DEPTH-1]));

  assign ctl.ins = fire && ins_ok;
  assign ctl.clr = fire && (in_tuser == tks_pkg::KIND_CLEAR);

  // row of cells, each fed by its left neighbor
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                  lv, ls;
    logic [COUNT_BITS-1:0] lc;
    logic [TOPIC_BITS-1:0] lt;
    if (i == 0) begin : g_head
      assign lv = 1'b1;
      assign ls = 1'b1;
      assign lc = '0;
      assign lt = '0;
    end else begin : g_body
      assign lv = valid_a[i-1];
      assign ls = stay_a[i-1];
      assign lc = count_a[i-1];
      assign lt = topic_a[i-1];
    end
    tks_cell #(
      .COUNT_BITS(COUNT_BITS),
      .TOPIC_BITS(TOPIC_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .new_count  (in_count),
      .new_topic  (in_topic),
      .left_valid (lv),
      .left_stay  (ls),
      .left_count (lc),
      .left_topic (lt),
      .valid      (valid_a[i]),
      .stay       (stay_a[i]),
      .count      (count_a[i]),
      .topic      (topic_a[i])
    );
  end

  always_comb begin
    held_nxt = held_r;
    if (ctl.clr) begin
      held_nxt = '0;
    end else if (ctl.ins && !full) begin
      held_nxt = held_r + 1'b1;
    end
  end

  // read select: an invalid cell reads as zero, which covers past-held reads
  always_comb begin
    rd_count_nxt = '0;
    rd_topic_nxt = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if ((i < (1 << tks_pkg::INDEX_W)) && (in_index == tks_pkg::INDEX_W'(i)) &&
          valid_a[i] && (in_tuser == tks_pkg::KIND_READ)) begin
        rd_count_nxt = count_a[i];
        rd_topic_nxt = topic_a[i];
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      acc_r      <= ins_ok;
      rd_count_r <= rd_count_nxt;
      rd_topic_r <= rd_topic_nxt;
    end
  end

  // held and max come live from the row: the state cannot move while a
  // result is pending, since no new word is taken until it leaves
  assign out_tvalid = out_valid_r;
  always_comb begin
    out_tdata = '0;
    out_tdata[0] = acc_r;
    out_tdata[1 +: HELD_W] = held_r;
    out_tdata[1 + HELD_W +: COUNT_BITS] = valid_a[0] ? count_a[0] : '0;
    out_tdata[1 + HELD_W + COUNT_BITS +: TOPIC_BITS] = valid_a[0] ? topic_a[0] : '0;
    out_tdata[1 + HELD_W + IDX_LO +: COUNT_BITS] = rd_count_r;
    out_tdata[1 + HELD_W + IDX_LO + COUNT_BITS +: TOPIC_BITS] = rd_topic_r;
  end

endmodule

// ----- dv/tks_tb_pkg.sv -----
// Prediction and checking for the top-K sorted insertion testbench.
// Depends on tks_pkg for the list depth and the kind codes.
package tks_tb_pkg;

  import tks_pkg::*;

  localparam int LIST_DEPTH = tks_pkg::DEPTH_DEF;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    bit        accepted;
    bit [4:0]  held;
    bit [31:0] max_count;
    bit [15:0] max_topic;
    bit [31:0] read_count;
    bit [15:0] read_topic;
  } topk_summary_t;

  class topk_tracker;
    bit [31:0]     pair_count[LIST_DEPTH];
    bit [15:0]     pair_topic[LIST_DEPTH];
    int unsigned   n_held;
    topk_summary_t pending_summaries[$];
    int unsigned   mismatches;

    function new();
      empty_list();
      mismatches = 0;
    endfunction

    function void empty_list();
      foreach (pair_count[i]) begin
        pair_count[i] = '0;
        pair_topic[i] = '0;
      end
      n_held = 0;
    endfunction

    // place the pair behind every key >= its own; full list needs a bigger count
    function bit insert_pair(bit [31:0] c, bit [15:0] t);
      int pos;
      int last;
      int n;
      int i;
      pos = 0;
      n = n_held;
      if (n >= LIST_DEPTH) begin
        n = LIST_DEPTH;
        if (!(c > pair_count[LIST_DEPTH-1])) return 1'b0;
        last = LIST_DEPTH - 1;
      end else begin
        last = n;
        n_held = n + 1;
      end
      while (pos < n && !({pair_count[pos], pair_topic[pos]} < {c, t})) pos++;
      if (pos > last) pos = last;
      for (i = last; i > pos; i--) begin
        pair_count[i] = pair_count[i-1];
        pair_topic[i] = pair_topic[i-1];
      end
      pair_count[pos] = c;
      pair_topic[pos] = t;
      return 1'b1;
    endfunction

    // accepted input word: update the list copy and queue the expected word
    function void note_word(bit [KIND_W-1:0] kind, bit [31:0] c, bit [15:0] t,
                            bit [INDEX_W-1:0] idx);
      topk_summary_t s;
      s.accepted   = 1'b0;
      s.read_count = '0;
      s.read_topic = '0;
      case (kind)
        KIND_INSERT: begin
          s.accepted = insert_pair(c, t);
        end
        KIND_CLEAR: begin
          empty_list();
        end
        KIND_READ: begin
          if (idx < n_held) begin
            s.read_count = pair_count[idx];
            s.read_topic = pair_topic[idx];
          end
        end
        default: ;
      endcase
      s.held      = n_held[4:0];
      s.max_count = pair_count[0];
      s.max_topic = pair_topic[0];
      pending_summaries.push_back(s);
    endfunction

    function void cmp_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        mismatches++;
      end
    endfunction

    // accepted output word, fields from bit 0:
    // accepted, held, max_count, max_topic, read_count, read_topic
    function void check_word(logic [103:0] data);
      topk_summary_t s;
      if (pending_summaries.size() == 0) begin
        $error("output word %0h with no prediction pending", data);
        mismatches++;
        return;
      end
      s = pending_summaries.pop_front();
      cmp_field("accepted",   32'(s.accepted),   32'(data[0]));
      cmp_field("held",       32'(s.held),       32'(data[5:1]));
      cmp_field("max_count",  s.max_count,       data[37:6]);
      cmp_field("max_topic",  32'(s.max_topic),  32'(data[53:38]));
      cmp_field("read_count", s.read_count,      data[85:54]);
      cmp_field("read_topic", 32'(s.read_topic), 32'(data[101:86]));
    endfunction
  endclass

endpackage

// ----- dv/tb_top.sv -----
// Testbench top for top_k_sorted_insert: clock, reset, stream driver and receiver.
// Depends on tks_pkg, tks_tb_pkg and the RTL of the block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tks_pkg::*;
  import tks_tb_pkg::*;

  localparam int IN_DW      = 56;
  localparam int OUT_DW     = 104;
  localparam int CYCLE_CAP  = 200000;
  localparam int RAND_WORDS = 1150;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  // from bit 0: count, topic, index, zero pad
  logic [IN_DW-1:0]  in_tdata = '0;
  // kind
  logic [KIND_W-1:0] in_tuser = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  // from bit 0: accepted, held, max_count, max_topic, read_count, read_topic, zero pad
  logic [OUT_DW-1:0] out_tdata;

  topk_tracker tracker = new();
  bit          no_gaps = 1'b0;  // burst stretch: both sides stop idling
  int unsigned cycle_cnt = 0;

  top_k_sorted_insert dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("top_k_sorted_insert verification failed");
      $finish;
    end
  end

  // one input word; called at a rising edge, returns at the edge it is taken.
  // valid stays high across back-to-back words (no lower/raise in one step).
  task automatic send_word(logic [KIND_W-1:0] kind, logic [31:0] c, logic [15:0] t,
                           logic [INDEX_W-1:0] idx);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {4'b0, idx, t, c};
    do @(posedge clk); while (!in_tready);
    tracker.note_word(kind, c, t, idx);
  endtask

  task automatic insert_pair(logic [31:0] c, logic [15:0] t);
    send_word(KIND_INSERT, c, t, 4'($urandom_range(0, 15)));
  endtask

  task automatic read_at(logic [INDEX_W-1:0] idx);
    send_word(KIND_READ, $urandom, 16'($urandom_range(0, 65535)), idx);
  endtask

  // directed: empty reads, extremes, ties, fill, drops at full, unused kind
  task automatic run_directed();
    read_at(4'd0);                       // read on empty list
    send_word(KIND_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 4'hF);
    insert_pair(32'd0, 16'd0);
    insert_pair(32'hFFFF_FFFF, 16'hFFFF);
    insert_pair(32'hFFFF_FFFF, 16'hFFFF); // equal key goes behind
    insert_pair(32'd7, 16'hFFFF);
    insert_pair(32'd7, 16'd0);
    insert_pair(32'd7, 16'hFFFF);
    repeat (10) insert_pair(32'd3, 16'($urandom_range(0, 65535)));  // now full
    insert_pair(32'd1, 16'd0);           // beats the zero count, zero drops off
    insert_pair(32'd1, 16'hFFFF);        // same count as last: dropped
    insert_pair(32'd0, 16'd5);           // below last: dropped
    insert_pair(32'hFFFF_FFFF, 16'd0);   // top count, smaller topic
    read_at(4'd15);
    read_at(4'd0);
    send_word(KIND_UNUSED, 32'd0, 16'd0, 4'd0);
    send_word(KIND_CLEAR, 32'd0, 16'd0, 4'd0);
    read_at(4'd15);                      // past held count
  endtask

  // random: mostly inserts so the list fills, rare clears, reads of any index.
  // count style changes every 100 words: narrow (ties, equal-to-last drops),
  // full range, or a mix crowding the top of the range.
  task automatic run_random();
    int          roll;
    int          style;
    logic [31:0] c;
    logic [15:0] t;
    style = 0;
    for (int n = 0; n < RAND_WORDS; n++) begin
      if (n % 100 == 0) begin
        style   = $urandom_range(0, 2);
        no_gaps = ($urandom_range(0, 3) == 0);
      end
      roll = $urandom_range(0, 99);
      case (style)
        0: begin
          c = $urandom_range(0, 24);
          t = 16'($urandom_range(0, 3));
        end
        1: begin
          c = $urandom;
          t = 16'($urandom_range(0, 65535));
        end
        default: begin
          c = ($urandom_range(0, 1) == 0) ? $urandom_range(32'hFFFF_FFF0, 32'hFFFF_FFFF)
                                          : $urandom;
          t = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535));
        end
      endcase
      if (roll < 2)
        send_word(KIND_CLEAR, c, t, 4'($urandom_range(0, 15)));
      else if (roll < 30)
        read_at(4'($urandom_range(0, 15)));
      else
        send_word(KIND_INSERT, c, t, 4'($urandom_range(0, 15)));
    end
    no_gaps = 1'b0;
  endtask

  // receiver: random stall per word, check each taken word
  initial begin
    do @(posedge clk); while (!rst_n);
    forever begin
      int stall;
      stall = no_gaps ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      tracker.check_word(out_tdata);
    end
  end

  // stimulus and end of run
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_random();
    in_tvalid <= 1'b0;
    while (tracker.pending_summaries.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (tracker.mismatches == 0)
      $display("top_k_sorted_insert verification clean");
    else
      $display("top_k_sorted_insert verification failed");
    $finish;
  end

endmodule
